// File: rtl/skt_pkg.sv
// Shared types, constants and codes for the sorted key table.
package skt_pkg;

  localparam int DEPTH  = 256;
  localparam int KEY_W  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_EXISTS    = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  localparam logic ACT_FIND   = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
  } skt_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] count_now;
  } skt_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE,
    S_DECIDE,
    S_SHIFT_START,
    S_SHIFT,
    S_WRITE,
    S_RESP
  } skt_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture input beat, open search window
    logic rd_mid;     // read the midpoint entry
    logic narrow;     // shrink the window after a mismatch
    logic set_found;  // record a match at the midpoint
    logic take_lo;    // record the insertion point
    logic shift_init; // start the shift pointer at the count
    logic shift_rd;   // read the first entry to move
    logic shift_wr;   // move one entry up, prefetch the next
    logic write_key;  // write the key at its place, bump the count
    logic emit;       // load the result register
  } skt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic window_open; // lo < hi
    logic key_eq;      // key equals the entry just read
    logic found;
    logic insert;
    logic full;
    logic shift_any;   // u > pos
    logic shift_more;  // u - 1 > pos
    logic out_free;
  } skt_stat_t;

endpackage

// File: rtl/skt_ram.sv
// Generic simple dual-port RAM with registered read.
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/skt_ctrl.sv
// Sequencer for search, shift and result phases.
module skt_ctrl import skt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  skt_stat_t stat,
  output skt_cmd_t  cmd
);

  skt_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PROBE;
      end
      S_PROBE: begin
        state_next = stat.window_open ? S_COMPARE : S_DECIDE;
      end
      S_COMPARE: begin
        state_next = stat.key_eq ? S_DECIDE : S_PROBE;
      end
      S_DECIDE: begin
        if (stat.insert && !stat.found && !stat.full) state_next = S_SHIFT_START;
        else state_next = S_RESP;
      end
      S_SHIFT_START: begin
        state_next = stat.shift_any ? S_SHIFT : S_WRITE;
      end
      S_SHIFT: begin
        if (!stat.shift_more) state_next = S_WRITE;
      end
      S_WRITE: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_PROBE: begin
        cmd.rd_mid  = stat.window_open;
        cmd.take_lo = !stat.window_open;
      end
      S_COMPARE: begin
        cmd.set_found = stat.key_eq;
        cmd.narrow    = !stat.key_eq;
      end
      S_DECIDE: begin
        cmd.shift_init = stat.insert && !stat.found && !stat.full;
      end
      S_SHIFT_START: begin
        cmd.shift_rd = stat.shift_any;
      end
      S_SHIFT: begin
        cmd.shift_wr = 1'b1;
      end
      S_WRITE: begin
        cmd.write_key = 1'b1;
      end
      S_RESP: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/skt_dp.sv
// Datapath: search window, shift pointer, key store and result register.
module skt_dp import skt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  skt_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output skt_out_t  out_data,
  input  skt_cmd_t  cmd,
  output skt_stat_t stat
);

  logic             signed_order;
  logic [CNT_W-1:0] count;
  logic             action;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] lo, hi, pos, u;
  logic             found;
  logic             inserted;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] span;
  logic [KEY_W-1:0] sign_flip;
  logic [KEY_W-1:0] key_ord, ent_ord;
  logic             key_lt;
  logic [KEY_W-1:0] rdata;
  logic             ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [CNT_W-1:0] u_m1, u_m2;
  logic [1:0]       status_code;

  // Midpoint of the search window
  assign span = hi - lo;
  assign mid  = lo + (span >> 1);

  // Map both keys so that an unsigned compare gives the selected order
  assign sign_flip = {signed_order, {(KEY_W-1){1'b0}}};
  assign key_ord   = key ^ sign_flip;
  assign ent_ord   = rdata ^ sign_flip;
  assign key_lt    = key_ord < ent_ord;

  assign u_m1 = u - CNT_W'(1);
  assign u_m2 = u - CNT_W'(2);

  // Status toward the controller
  always_comb begin
    stat.window_open = lo < hi;
    stat.key_eq      = key_ord == ent_ord;
    stat.found       = found;
    stat.insert      = action == ACT_INSERT;
    stat.full        = count == CNT_W'(DEPTH);
    stat.shift_any   = u > pos;
    stat.shift_more  = u_m1 > pos;
    stat.out_free    = !out_valid || out_ready;
  end

  // Order register
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_order <= 1'b0;
    end else if (cfg_we) begin
      signed_order <= cfg_wdata;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.write_key) begin
      count <= count + CNT_W'(1);
    end
  end

  // Capture the beat and run the search window
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action   <= in_data.action;
      key      <= in_data.key;
      lo       <= '0;
      hi       <= count;
      found    <= 1'b0;
      inserted <= 1'b0;
    end
    if (cmd.narrow) begin
      if (key_lt) hi <= mid;
      else lo <= mid + CNT_W'(1);
    end
    if (cmd.set_found) begin
      found <= 1'b1;
      pos   <= mid;
    end
    if (cmd.take_lo) begin
      pos <= lo;
    end
    if (cmd.write_key) begin
      inserted <= 1'b1;
    end
  end

  // Shift pointer walks down from the count
  always_ff @(posedge clk) begin
    if (cmd.shift_init) begin
      u <= count;
    end else if (cmd.shift_wr) begin
      u <= u_m1;
    end
  end

  // Memory port selection
  always_comb begin
    ram_re    = cmd.rd_mid || cmd.shift_rd || (cmd.shift_wr && stat.shift_more);
    ram_raddr = mid[ADDR_W-1:0];
    if (cmd.shift_rd) ram_raddr = u_m1[ADDR_W-1:0];
    else if (cmd.shift_wr) ram_raddr = u_m2[ADDR_W-1:0];
    ram_we    = cmd.shift_wr || cmd.write_key;
    ram_waddr = cmd.write_key ? pos[ADDR_W-1:0] : u[ADDR_W-1:0];
    ram_wdata = cmd.write_key ? key : rdata;
  end

  skt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Result code
  always_comb begin
    if (action == ACT_FIND) status_code = found ? STAT_OK : STAT_NOT_FOUND;
    else if (found) status_code = STAT_EXISTS;
    else status_code = inserted ? STAT_OK : STAT_FULL;
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.status    <= status_code;
      out_data.position  <= pos;
      out_data.count_now <= count;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("entry count above depth");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    cmd.write_key |-> (count < CNT_W'(DEPTH)) && !found)
    else $error("key write into full table or on a match");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> (u > pos) && (u < CNT_W'(DEPTH)))
    else $error("shift step outside the moved range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

endmodule

// File: rtl/sorted_key_table_core.sv
// Top level of the sorted key table: controller plus datapath.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    in_data  (action, key)
//  out      output     out_valid/out_ready  out_data (status, position, count_now)
//  cfg      input      cfg_we               cfg_wdata (signed_order)
//
// One item at a time. A find runs a binary search, reading and comparing the
// midpoint entry at each step; an insert then shifts each larger entry up one
// place and writes the key, through the single key store write port. Reset
// clears the count, the order register and the result valid flag; the key store
// needs no clearing. A stalled result holds in its register and the next beat is
// taken once it has been loaded there.
module sorted_key_table_core import skt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     in_valid,
  output logic     in_ready,
  input  skt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output skt_out_t out_data
);

  skt_cmd_t  cmd;
  skt_stat_t stat;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  skt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: sim/sorted_key_table_core_tb.sv
`timescale 1ns / 100ps
// Testbench for sorted_key_table_core: directed rows, then random find/insert traffic.
module sorted_key_table_core_tb import skt_pkg::*; ();

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_BEATS = 230;
  localparam int DIR_ROWS    = 18;
  localparam int DRAIN_WAIT  = 300;

  typedef struct packed {
    logic             act;
    logic [KEY_W-1:0] key;
    logic             typed;
    logic [1:0]       status;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] count_now;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  logic     cfg_wdata;
  logic     in_valid;
  logic     in_ready;
  skt_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  skt_out_t out_data;

  // Behavioral copy of the table
  logic [KEY_W-1:0] model_keys [DEPTH];
  int unsigned      model_count;
  logic             model_signed;

  skt_out_t    replies_due[$];
  int          fail_count;
  int unsigned cycles;
  int          send_left, recv_left;
  bit          send_calm, recv_calm;

  // Directed rows, unsigned order; typed rows carry their reply
  plan_row_t plan [DIR_ROWS] = '{
    '{ACT_FIND,   32'h0000_0000, 1'b1, STAT_NOT_FOUND, 9'd0, 9'd0},
    '{ACT_FIND,   32'hFFFF_FFFF, 1'b1, STAT_NOT_FOUND, 9'd0, 9'd0},
    '{ACT_INSERT, 32'h8000_0000, 1'b1, STAT_OK,        9'd0, 9'd1},
    '{ACT_INSERT, 32'h8000_0000, 1'b1, STAT_EXISTS,    9'd0, 9'd1},
    '{ACT_INSERT, 32'h0000_0000, 1'b1, STAT_OK,        9'd0, 9'd2},
    '{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, STAT_OK,        9'd2, 9'd3},
    '{ACT_INSERT, 32'h7FFF_FFFF, 1'b1, STAT_OK,        9'd1, 9'd4},
    '{ACT_FIND,   32'h7FFF_FFFF, 1'b1, STAT_OK,        9'd1, 9'd4},
    '{ACT_FIND,   32'hFFFF_FFFF, 1'b1, STAT_OK,        9'd3, 9'd4},
    '{ACT_FIND,   32'h0000_0001, 1'b1, STAT_NOT_FOUND, 9'd1, 9'd4},
    '{ACT_FIND,   32'h8000_0001, 1'b1, STAT_NOT_FOUND, 9'd3, 9'd4},
    '{ACT_INSERT, 32'hFFFF_FFFF, 1'b1, STAT_EXISTS,    9'd3, 9'd4},
    '{ACT_INSERT, 32'h5555_5555, 1'b1, STAT_OK,        9'd1, 9'd5},
    '{ACT_INSERT, 32'hAAAA_AAAA, 1'b1, STAT_OK,        9'd4, 9'd6},
    '{ACT_FIND,   32'h0000_0000, 1'b1, STAT_OK,        9'd0, 9'd6},
    '{ACT_INSERT, 32'h1234_5678, 1'b0, STAT_OK,        9'd0, 9'd0},
    '{ACT_FIND,   32'h0000_0002, 1'b0, STAT_OK,        9'd0, 9'd0},
    '{ACT_INSERT, 32'hFFFF_FFFE, 1'b0, STAT_OK,        9'd0, 9'd0}
  };

  sorted_key_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Map a key so that unsigned compare follows the selected order
  function automatic logic [KEY_W-1:0] order_rank(logic [KEY_W-1:0] k);
    return model_signed ? {~k[KEY_W-1], k[KEY_W-2:0]} : k;
  endfunction

  // Search the table, apply an insert, and return the reply
  function automatic skt_out_t lookup_or_insert(skt_in_t beat);
    int       lo;
    int       hi;
    int       mid;
    int       u;
    bit       hit;
    skt_out_t r;
    lo  = 0;
    hi  = model_count;
    hit = 1'b0;
    while (lo < hi && !hit) begin
      mid = lo + ((hi - lo) >> 1);
      if (order_rank(beat.key) < order_rank(model_keys[mid])) begin
        hi = mid;
      end else if (order_rank(beat.key) > order_rank(model_keys[mid])) begin
        lo = mid + 1;
      end else begin
        hit = 1'b1;
        lo  = mid;
      end
    end
    r.position = CNT_W'(lo);
    if (beat.action == ACT_FIND) begin
      r.status = hit ? STAT_OK : STAT_NOT_FOUND;
    end else if (hit) begin
      r.status = STAT_EXISTS;
    end else if (model_count >= DEPTH) begin
      r.status = STAT_FULL;
    end else begin
      // shift larger entries up and drop the key in the gap
      for (u = model_count; u > lo; u--) model_keys[u] = model_keys[u-1];
      model_keys[lo] = beat.key;
      model_count++;
      r.status = STAT_OK;
    end
    r.count_now = CNT_W'(model_count);
    return r;
  endfunction

  // Draw an idle gap; stretches of zero gaps come now and then
  function automatic int draw_wait(inout int run_left, inout bit run_calm);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 40);
      run_calm = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return run_calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Pick keys near held entries most of the time, so hits and neighbors are common
  function automatic skt_in_t random_beat();
    skt_in_t          b;
    logic [KEY_W-1:0] held;
    b.action = ($urandom_range(0, 99) < 55) ? ACT_INSERT : ACT_FIND;
    held = (model_count != 0) ? model_keys[$urandom_range(0, model_count - 1)] : $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b.key = held;
      4: b.key = held + 1'b1;
      5: b.key = held - 1'b1;
      6: begin
        case ($urandom_range(0, 3))
          0: b.key = '0;
          1: b.key = '1;
          2: b.key = {1'b1, {(KEY_W-1){1'b0}}};
          default: b.key = {1'b0, {(KEY_W-1){1'b1}}};
        endcase
      end
      default: b.key = $urandom;
    endcase
    return b;
  endfunction

  // Offer one beat after a random gap and log its reply once accepted
  task automatic send_beat(skt_in_t beat, bit typed, skt_out_t want);
    int       gap;
    skt_out_t predicted;
    gap = draw_wait(send_left, send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    predicted = lookup_or_insert(beat);
    replies_due.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_order(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    model_signed  = v;
  endtask

  task automatic run_phase(logic order, int beats);
    skt_out_t none;
    none = '0;
    wait_drained();
    set_order(order);
    repeat (beats) send_beat(random_beat(), 1'b0, none);
    in_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    skt_in_t  beat;
    skt_out_t want;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    for (int i = 0; i < DEPTH; i++) model_keys[i] = '0;
    model_count  = 0;
    model_signed = 1'b0;
    fail_count   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_order(1'b0);

    // Walk the directed table
    foreach (plan[i]) begin
      beat.action     = plan[i].act;
      beat.key        = plan[i].key;
      want.status     = plan[i].status;
      want.position   = plan[i].position;
      want.count_now  = plan[i].count_now;
      send_beat(beat, plan[i].typed, want);
    end
    in_valid <= 1'b0;

    // Random phases, alternating the compare order while entries are held
    run_phase(1'b1, PHASE_BEATS);
    run_phase(1'b0, PHASE_BEATS);
    run_phase(1'b1, PHASE_BEATS);
    run_phase(1'b0, PHASE_BEATS);
    run_phase(1'b1, PHASE_BEATS);
    run_phase(1'b0, PHASE_BEATS);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_key_table_core test passed");
    end else begin
      $display("sorted_key_table_core test failed");
    end
    $finish;
  end

  // Stall the result side at random
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = draw_wait(recv_left, recv_calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1));
    end
  end

  // Compare each result beat with the oldest reply due
  always @(posedge clk) begin
    skt_out_t want;
    if (rst == 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = replies_due.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          fail_count++;
        end
        if (out_data.position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   out_data.position);
          fail_count++;
        end
        if (out_data.count_now !== want.count_now) begin
          $display("%0t: count_now expected %0d actual %0d", $time, want.count_now,
                   out_data.count_now);
          fail_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sorted_key_table_core test failed");
      $finish;
    end
  end

endmodule

// File: files.f
rtl/skt_pkg.sv
rtl/skt_ram.sv
rtl/skt_ctrl.sv
rtl/skt_dp.sv
rtl/sorted_key_table_core.sv
sim/sorted_key_table_core_tb.sv
